[rtl/core/upca_pkg.sv]
// Shared types, constants and code tables for the UPC-A scanline decoder.
`timescale 1ns / 1ps
`default_nettype none

package upca_pkg;

    // Line buffer geometry
    localparam int MAX_LINE_WIDTH = 4096;
    localparam int ADDR_W         = $clog2(MAX_LINE_WIDTH);
    localparam int CNT_W          = ADDR_W + 1;

    // Symbol geometry
    localparam int MODULE_COUNT   = 95;
    localparam int DIGIT_MODULES  = 7;
    localparam int HALF_DIGITS    = 6;
    localparam int NUM_DIGITS     = 2 * HALF_DIGITS;
    localparam int LEFT_START     = 3;
    localparam int RIGHT_START    = 50;
    localparam int MOD_W          = 7;
    localparam int BIT_W          = 3;
    localparam int DIGIT_W        = 4;

    // span / 95 as (span * 345) >> 15, exact for spans up to 4096
    localparam int STEP_RECIP     = 345;
    localparam int RECIP_W        = 9;
    localparam int STEP_SHIFT     = 15;
    localparam int STEP_W         = 6;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOMATCH = 2'd1,
        ST_SHORT   = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0] pixel_red;
        logic       line_end;
    } pixel_t;

    typedef struct packed {
        logic [3:0] digit_index;
        logic [3:0] digit_value;
        status_t    status;
        logic       last_digit;
    } result_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_ADDR,
        S_DATA,
        S_EMIT,
        S_SHORT
    } ctrl_state_t;

    typedef struct packed {
        logic take_pixel;
        logic calc_step;
        logic read_bit;
        logic shift_bit;
        logic emit_digit;
        logic emit_short;
        logic clear_line;
    } dp_cmd_t;

    typedef struct packed {
        logic short_span;
        logic bit_last;
        logic digit_last;
        logic res_free;
    } dp_status_t;

    typedef struct packed {
        logic       hit;
        logic [3:0] value;
    } match_t;

    localparam logic [6:0] L_CODES [10] = '{
        7'h0D, 7'h19, 7'h13, 7'h3D, 7'h23, 7'h31, 7'h2F, 7'h3B, 7'h37, 7'h0B
    };
    localparam logic [6:0] R_CODES [10] = '{
        7'h72, 7'h66, 7'h6C, 7'h42, 7'h5C, 7'h4E, 7'h50, 7'h44, 7'h48, 7'h74
    };

    // First module of digit d
    function automatic logic [MOD_W-1:0] module_base(input logic [DIGIT_W-1:0] d);
        logic [MOD_W-1:0] dd;
        dd = MOD_W'(d);
        if (d < DIGIT_W'(HALF_DIGITS))
            module_base = MOD_W'(LEFT_START) + dd * MOD_W'(DIGIT_MODULES);
        else
            module_base = MOD_W'(RIGHT_START)
                        + (dd - MOD_W'(HALF_DIGITS)) * MOD_W'(DIGIT_MODULES);
    endfunction

    // First code in the table that equals the pattern
    function automatic match_t match_code(input logic [6:0] pat, input logic right);
        match_t m;
        logic [6:0] code;
        m = '0;
        for (int v = 9; v >= 0; v--) begin
            code = right ? R_CODES[v] : L_CODES[v];
            if (code == pat) begin
                m.hit   = 1'b1;
                m.value = 4'(v);
            end
        end
        match_code = m;
    endfunction

endpackage

`default_nettype wire

[rtl/core/upca_scanline_decoder.sv]
// Top level of the UPC-A scanline decoder: controller, datapath and config port.
`timescale 1ns / 1ps
`default_nettype none

// Pixels of one scanline stream in one per clock while pix_stall is low; each
// pixel's bar bit (red below the configured threshold) goes into a 4096 x 1
// line buffer, while the first and last bar positions are tracked. Pixels
// past 4096 are dropped. The pixel flagged line_end closes the line: the
// check state tests the span, forms step = span/95 by a reciprocal multiply,
// then each of the 84 data modules is sampled (address, registered buffer
// read) and each digit is then matched and loaded into the result register;
// no new pixel is taken until the line is done (later if res_stall holds
// results back). Twelve transactions follow, digits 0-11, the last one
// flagged last_digit; a line with no bar or a span under 95 pixels yields a
// single transaction with status 2. The result register lets a new line
// start while the final result still waits. The line buffer is not cleared
// after reset; only positions written in the current line are read.
// cfg_ready is always high; write the threshold only while the block is idle.

module upca_scanline_decoder (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               pix_valid,
    output logic                    pix_stall,
    input  wire upca_pkg::pixel_t   pix_data,
    output logic                    res_valid,
    input  wire logic               res_stall,
    output upca_pkg::result_t       res_data,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [7:0]         cfg_data
);

    upca_pkg::dp_cmd_t    cmd;
    upca_pkg::dp_status_t stat;

    assign cfg_ready = 1'b1;

    upca_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .line_end  (pix_data.line_end),
        .pix_stall (pix_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    upca_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_data  (pix_data),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .res_stall (res_stall),
        .res_valid (res_valid),
        .res_data  (res_data),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

`default_nettype wire

[rtl/core/upca_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module upca_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[rtl/core/upca_dp.sv]
// Datapath: line capture, bar span tracking, module sampling and result register.
`timescale 1ns / 1ps
`default_nettype none

module upca_dp (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire upca_pkg::pixel_t     pix_data,
    input  wire logic                 cfg_write,
    input  wire logic [7:0]           cfg_data,
    input  wire logic                 res_stall,
    output logic                      res_valid,
    output upca_pkg::result_t         res_data,
    input  wire upca_pkg::dp_cmd_t    cmd,
    output upca_pkg::dp_status_t      stat
);

    localparam int CW = upca_pkg::CNT_W;
    localparam int AW = upca_pkg::ADDR_W;
    localparam int PW = upca_pkg::CNT_W + upca_pkg::RECIP_W;

    logic [7:0]                       thresh_reg, thresh_next;
    logic [CW-1:0]                    count_reg, count_next;
    logic [AW-1:0]                    first_reg, first_next;
    logic [AW-1:0]                    last_reg, last_next;
    logic                             seen_reg, seen_next;
    logic [upca_pkg::STEP_W-1:0]      step_reg, step_next;
    logic [upca_pkg::DIGIT_W-1:0]     digit_reg, digit_next;
    logic [upca_pkg::BIT_W-1:0]       bit_reg, bit_next;
    logic [6:0]                       pat_reg, pat_next;
    logic                             inrange_reg, inrange_next;
    logic                             res_valid_reg, res_valid_next;
    upca_pkg::result_t                res_reg, res_next;

    logic                             is_bar;
    logic                             room;
    logic                             ram_we;
    logic                             ram_rdata;
    logic [CW-1:0]                    span;
    logic [PW-1:0]                    step_full;
    logic [upca_pkg::MOD_W-1:0]       module_idx;
    logic [CW-1:0]                    offset;
    logic [CW-1:0]                    pos;
    upca_pkg::match_t                 match;

    assign is_bar = pix_data.pixel_red < thresh_reg;
    assign room   = count_reg < CW'(upca_pkg::MAX_LINE_WIDTH);
    assign ram_we = cmd.take_pixel && room;

    assign span      = {1'b0, last_reg} - {1'b0, first_reg} + CW'(1);
    assign step_full = PW'(span) * PW'(upca_pkg::STEP_RECIP);

    assign module_idx = upca_pkg::module_base(digit_reg)
                      + upca_pkg::MOD_W'(bit_reg);
    assign offset     = CW'(module_idx) * CW'(step_reg);
    assign pos        = {1'b0, first_reg} + offset;

    assign match = upca_pkg::match_code(pat_reg,
                                        digit_reg >= upca_pkg::DIGIT_W'(upca_pkg::HALF_DIGITS));

    assign stat.short_span = !seen_reg || (span < CW'(upca_pkg::MODULE_COUNT));
    assign stat.bit_last   = bit_reg == upca_pkg::BIT_W'(upca_pkg::DIGIT_MODULES - 1);
    assign stat.digit_last = digit_reg == upca_pkg::DIGIT_W'(upca_pkg::NUM_DIGITS - 1);
    assign stat.res_free   = !res_valid_reg || !res_stall;

    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

    upca_ram #(
        .WIDTH (1),
        .DEPTH (upca_pkg::MAX_LINE_WIDTH)
    ) u_bar_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (is_bar),
        .re    (cmd.read_bit),
        .raddr (pos[AW-1:0]),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        thresh_next    = thresh_reg;
        count_next     = count_reg;
        first_next     = first_reg;
        last_next      = last_reg;
        seen_next      = seen_reg;
        step_next      = step_reg;
        digit_next     = digit_reg;
        bit_next       = bit_reg;
        pat_next       = pat_reg;
        inrange_next   = inrange_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && res_stall;

        if (cfg_write)
            thresh_next = cfg_data;

        if (ram_we)
        begin
            count_next = count_reg + CW'(1);
            if (is_bar)
            begin
                if (!seen_reg)
                    first_next = count_reg[AW-1:0];
                last_next = count_reg[AW-1:0];
                seen_next = 1'b1;
            end
        end

        if (cmd.calc_step)
        begin
            step_next  = step_full[upca_pkg::STEP_SHIFT +: upca_pkg::STEP_W];
            digit_next = '0;
            bit_next   = '0;
            pat_next   = '0;
        end

        if (cmd.read_bit)
            inrange_next = pos < CW'(upca_pkg::MAX_LINE_WIDTH);

        if (cmd.shift_bit)
        begin
            pat_next = {pat_reg[5:0], ram_rdata && inrange_reg};
            bit_next = bit_reg + upca_pkg::BIT_W'(1);
        end

        if (cmd.emit_digit)
        begin
            res_valid_next      = 1'b1;
            res_next.digit_index = digit_reg;
            res_next.digit_value = match.hit ? match.value : 4'd0;
            res_next.status      = match.hit ? upca_pkg::ST_OK : upca_pkg::ST_NOMATCH;
            res_next.last_digit  = stat.digit_last;
            digit_next           = digit_reg + upca_pkg::DIGIT_W'(1);
            bit_next             = '0;
            pat_next             = '0;
        end

        if (cmd.emit_short)
        begin
            res_valid_next       = 1'b1;
            res_next.digit_index = '0;
            res_next.digit_value = '0;
            res_next.status      = upca_pkg::ST_SHORT;
            res_next.last_digit  = 1'b1;
        end

        if (cmd.clear_line)
        begin
            count_next = '0;
            first_next = '0;
            last_next  = '0;
            seen_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg    <= 8'd127;
            count_reg     <= '0;
            first_reg     <= '0;
            last_reg      <= '0;
            seen_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            thresh_reg    <= thresh_next;
            count_reg     <= count_next;
            first_reg     <= first_next;
            last_reg      <= last_next;
            seen_reg      <= seen_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg    <= step_next;
        digit_reg   <= digit_next;
        bit_reg     <= bit_next;
        pat_reg     <= pat_next;
        inrange_reg <= inrange_next;
        res_reg     <= res_next;
    end

endmodule

`default_nettype wire

[rtl/core/upca_ctrl.sv]
// Controller: sequences pixel capture, span check, module sampling and result issue.
`timescale 1ns / 1ps
`default_nettype none

module upca_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  pix_valid,
    input  wire logic                  line_end,
    output logic                       pix_stall,
    output upca_pkg::dp_cmd_t          cmd,
    input  wire upca_pkg::dp_status_t  stat
);

    upca_pkg::ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= upca_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        pix_stall  = 1'b1;

        unique case (state_reg)
            upca_pkg::S_IDLE:
            begin
                pix_stall      = 1'b0;
                cmd.take_pixel = pix_valid;
                if (pix_valid && line_end)
                    state_next = upca_pkg::S_CHECK;
            end
            upca_pkg::S_CHECK:
            begin
                cmd.calc_step = 1'b1;
                state_next    = stat.short_span ? upca_pkg::S_SHORT : upca_pkg::S_ADDR;
            end
            upca_pkg::S_ADDR:
            begin
                cmd.read_bit = 1'b1;
                state_next   = upca_pkg::S_DATA;
            end
            upca_pkg::S_DATA:
            begin
                cmd.shift_bit = 1'b1;
                state_next    = stat.bit_last ? upca_pkg::S_EMIT : upca_pkg::S_ADDR;
            end
            upca_pkg::S_EMIT:
            begin
                if (stat.res_free)
                begin
                    cmd.emit_digit = 1'b1;
                    if (stat.digit_last)
                    begin
                        cmd.clear_line = 1'b1;
                        state_next     = upca_pkg::S_IDLE;
                    end
                    else
                        state_next = upca_pkg::S_ADDR;
                end
            end
            upca_pkg::S_SHORT:
            begin
                if (stat.res_free)
                begin
                    cmd.emit_short = 1'b1;
                    cmd.clear_line = 1'b1;
                    state_next     = upca_pkg::S_IDLE;
                end
            end
            default:
                state_next = upca_pkg::S_IDLE;
        endcase
    end

endmodule

`default_nettype wire
